>>> rtl/core/skb_pkg.sv
// ----------------------------------------------------------------------------
// skb_pkg
// Shared types, constants and helpers for the k-skyband filter core.
// ----------------------------------------------------------------------------
package skb_pkg;

  localparam int MAX_BAND   = 16;
  localparam int COORD_BITS = 16;
  localparam int RANK_W     = 16;
  localparam int DEPTH_W    = 5;
  localparam int CLASS_W    = 2;
  // held count must reach MAX_BAND itself
  localparam int BAND_W     = $clog2(MAX_BAND + 1);
  localparam int IDX_W      = (MAX_BAND > 1) ? $clog2(MAX_BAND) : 1;

  localparam logic [CLASS_W-1:0] CLASS_DROP    = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_SKYLINE = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_BAND    = 2'd2;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd1;

  typedef struct packed {
    logic                  first_point;
    logic [COORD_BITS-1:0] x_coord;
    logic [COORD_BITS-1:0] y_coord;
  } skb_in_t;

  typedef struct packed {
    logic [CLASS_W-1:0]    point_class;
    logic [RANK_W-1:0]     skyband_rank;
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
  } skb_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic commit;
  } skb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } skb_sts_t;

  // zero acts as one, anything above MAX_BAND clamps
  function automatic logic [BAND_W-1:0] effective_depth(logic [DEPTH_W-1:0] d);
    logic [31:0] d32;
    d32 = 32'(d);
    if (d32 == 32'd0) begin
      return BAND_W'(1);
    end
    if (d32 > 32'(MAX_BAND)) begin
      return BAND_W'(MAX_BAND);
    end
    return BAND_W'(d32);
  endfunction

endpackage

>>> rtl/core/skb_ctrl.sv
// ----------------------------------------------------------------------------
// skb_ctrl
// Sequencer: load a point, scan the held set for its minimum, then commit.
// ----------------------------------------------------------------------------
module skb_ctrl
  import skb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  skb_sts_t sts,
  output skb_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_COMMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/skb_datapath.sv
// ----------------------------------------------------------------------------
// skb_datapath
// Held largest-x set, running max and rank, minimum scan and output register.
// ----------------------------------------------------------------------------
module skb_datapath
  import skb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  skb_cmd_t           cmd,
  output skb_sts_t           sts,
  input  skb_in_t            in_data,
  input  logic               cfg_wr,
  input  logic [DEPTH_W-1:0] cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output skb_out_t           out_data
);

  logic [DEPTH_W-1:0]    depth_r;
  logic [COORD_BITS-1:0] set_r [MAX_BAND];
  logic [BAND_W-1:0]     held_r;
  logic [COORD_BITS-1:0] max_x_r;
  logic [RANK_W-1:0]     acc_r;

  skb_in_t               item_r;
  logic [BAND_W-1:0]     idx_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [COORD_BITS-1:0] best_val_r;

  logic                  out_valid_r;
  skb_out_t              out_data_r;

  logic [BAND_W-1:0]     k_eff;
  logic                  below_k;
  logic                  accept;
  logic                  skyline;
  logic [RANK_W-1:0]     acc_nxt;
  logic [IDX_W-1:0]      wr_idx;

  assign k_eff   = effective_depth(depth_r);
  assign below_k = (held_r < k_eff);
  assign accept  = below_k || (item_r.x_coord > best_val_r);
  assign skyline = (item_r.x_coord > max_x_r);
  assign acc_nxt = (acc_r == '1) ? acc_r : acc_r + RANK_W'(1);
  // fill the next free slot while growing, else overwrite the minimum
  assign wr_idx  = below_k ? held_r[IDX_W-1:0] : best_idx_r;

  assign sts.scan_done = (idx_r >= held_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // config register and control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= DEPTH_RESET;
      held_r      <= '0;
      max_x_r     <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        depth_r <= cfg_data;
      end
      if (cmd.load && in_data.first_point) begin
        held_r  <= '0;
        max_x_r <= '0;
        acc_r   <= '0;
      end else if (cmd.commit && accept) begin
        acc_r <= acc_nxt;
        if (skyline) begin
          max_x_r <= item_r.x_coord;
        end
        if (below_k) begin
          held_r <= held_r + BAND_W'(1);
        end
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: item, scan, held set, result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      idx_r  <= '0;
    end
    if (cmd.scan_step) begin
      // strict compare keeps the lowest index on ties
      if ((idx_r == '0) || (set_r[idx_r[IDX_W-1:0]] < best_val_r)) begin
        best_val_r <= set_r[idx_r[IDX_W-1:0]];
        best_idx_r <= idx_r[IDX_W-1:0];
      end
      idx_r <= idx_r + BAND_W'(1);
    end
    if (cmd.commit) begin
      if (accept) begin
        set_r[wr_idx] <= item_r.x_coord;
      end
      out_data_r.point_class  <= !accept ? CLASS_DROP :
                                 (skyline ? CLASS_SKYLINE : CLASS_BAND);
      out_data_r.skyband_rank <= accept ? acc_nxt : '0;
      out_data_r.out_x        <= item_r.x_coord;
      out_data_r.out_y        <= item_r.y_coord;
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= BAND_W'(MAX_BAND))
    else $error("held count above MAX_BAND");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> (idx_r < held_r))
    else $error("scan past held entries");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not raise out_valid");

  a_rank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && accept) |=> (out_data_r.skyband_rank != '0))
    else $error("accepted point with zero rank");

endmodule

>>> rtl/core/k_skyband_filter_core.sv
// ----------------------------------------------------------------------------
// k_skyband_filter_core
// Streaming 2-D k-skyband classifier for points sorted by y descending.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one point per beat (first_point, x_coord, y_coord). first_point
//            clears the held set, running max x and rank before the point.
//   out_*  : one result beat per point: class (dropped / skyline / band),
//            saturating rank of accepted points, x and y passed through.
//   cfg_*  : band depth k, 5 bits; 0 acts as 1, above MAX_BAND clamps.
//            cfg_ready is always high; write only while the core is idle.
// Sequence:
//   After a point is accepted, the held entries are scanned one by one for
//   the minimum, the scan settles, the commit state writes the set and the
//   result register, and idle takes the next beat. in_stall stays high
//   until the core is back in idle.
// Reset (rst_n, synchronous): empty set, rank and max x zero, k = 1.
// Back pressure: the result sits in an output register; while it is stalled
//   the next commit waits and in_stall stays high, nothing is lost.
// ----------------------------------------------------------------------------
module k_skyband_filter_core
  import skb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // point input
  input  logic               in_valid,
  output logic               in_stall,
  input  skb_in_t            in_data,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output skb_out_t           out_data,
  // band depth register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [DEPTH_W-1:0] cfg_data
);

  skb_cmd_t cmd;
  skb_sts_t sts;
  logic     cfg_wr;

  // register takes a write any cycle
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  skb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  skb_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_wr    (cfg_wr),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> dv/skb_class_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skb_class_check
// Watches the point, result and band depth channels of the k-skyband core,
// keeps its own copy of the held x set, peak x and rank, works out the class
// of each accepted point and compares every result beat with it in order.
// ----------------------------------------------------------------------------
module skb_class_check
  import skb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  skb_in_t            in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  skb_out_t           out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [DEPTH_W-1:0] cfg_data,
  output int unsigned        mismatches,
  output int unsigned        results_owed
);

  logic [COORD_BITS-1:0] band_x_held [MAX_BAND];
  int unsigned           n_held;
  logic [COORD_BITS-1:0] x_peak;
  logic [RANK_W-1:0]     n_accepted;
  logic [DEPTH_W-1:0]    depth_reg;
  skb_out_t              classes_due [$];

  always @(posedge clk) begin : track
    skb_out_t    want;
    skb_out_t    got;
    int unsigned k;
    int unsigned low_slot;
    int unsigned errs;
    logic        admit;
    errs = 0;
    if (!rst_n) begin
      depth_reg  = DEPTH_RESET;
      n_held     = 0;
      x_peak     = '0;
      n_accepted = '0;
      classes_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        depth_reg = cfg_data;
      end
      if (in_valid && !in_stall) begin
        if (in_data.first_point) begin
          n_held     = 0;
          x_peak     = '0;
          n_accepted = '0;
        end
        // zero acts as one, above MAX_BAND clamps
        k = 32'(depth_reg);
        if (k == 0) begin
          k = 1;
        end else if (k > MAX_BAND) begin
          k = MAX_BAND;
        end
        low_slot = 0;
        for (int i = 1; i < n_held; i++) begin
          if (band_x_held[i] < band_x_held[low_slot]) begin
            low_slot = i;
          end
        end
        admit = (n_held < k) || (in_data.x_coord > band_x_held[low_slot]);
        want.point_class  = CLASS_DROP;
        want.skyband_rank = '0;
        want.out_x        = in_data.x_coord;
        want.out_y        = in_data.y_coord;
        if (admit) begin
          if (n_accepted != '1) begin
            n_accepted = n_accepted + RANK_W'(1);
          end
          want.skyband_rank = n_accepted;
          if (in_data.x_coord > x_peak) begin
            want.point_class = CLASS_SKYLINE;
            x_peak           = in_data.x_coord;
          end else begin
            want.point_class = CLASS_BAND;
          end
          // room below k: append; set full (or depth lowered below it): replace the smallest
          if (n_held < k) begin
            band_x_held[n_held] = in_data.x_coord;
            n_held++;
          end else begin
            band_x_held[low_slot] = in_data.x_coord;
          end
        end
        classes_due.insert(classes_due.size(), want);
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (classes_due.size() == 0) begin
          $error("result beat with no point outstanding: point_class %0d, out_x %0h",
                 got.point_class, got.out_x);
          errs++;
        end else begin
          want = classes_due.pop_front();
          if (got.point_class !== want.point_class) begin
            $error("point_class: expected %0d, got %0d", want.point_class, got.point_class);
            errs++;
          end
          if (got.skyband_rank !== want.skyband_rank) begin
            $error("skyband_rank: expected %0d, got %0d", want.skyband_rank,
                   got.skyband_rank);
            errs++;
          end
          if (got.out_x !== want.out_x) begin
            $error("out_x: expected %0h, got %0h", want.out_x, got.out_x);
            errs++;
          end
          if (got.out_y !== want.out_y) begin
            $error("out_y: expected %0h, got %0h", want.out_y, got.out_y);
            errs++;
          end
        end
      end
    end
    mismatches   <= mismatches + errs;
    results_owed <= classes_due.size();
  end

endmodule

>>> dv/k_skyband_filter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_skyband_filter_core_test
// Drives sorted point streams, noise points and band depth writes into the
// k-skyband core under several mixes of sender gaps and receiver stalls; a
// side checker predicts every result and this top gives the verdict.
// ----------------------------------------------------------------------------
module k_skyband_filter_core_test;
  import skb_pkg::*;

  // apart from stalls a point's time is bounded by the held set size, and stall
  // runs at 54% are short, so reaching QUIET_LIMIT only happens when the core is hung
  localparam int unsigned QUIET_LIMIT   = 4000;
  // drain margin before a depth write and before the verdict
  localparam int unsigned SETTLE_CYCLES = MAX_BAND + 8;
  localparam int unsigned RUN_POINTS    = 140;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  skb_in_t            in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  skb_out_t           out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [DEPTH_W-1:0] cfg_data  = '0;

  int unsigned gap_pct   = 0;   // chance per beat slot that the sender idles
  int unsigned stall_pct = 0;   // chance per cycle that the receiver stalls
  int unsigned mismatches;
  int unsigned results_owed;
  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  k_skyband_filter_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  skb_class_check u_class_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  // receiver back pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog: any beat on any channel (or reset) restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("k_skyband_filter_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One point beat. Random idle slots first, then valid is held with a
  // steady payload until the beat is taken. Returns on the accept edge with
  // in_valid still high, so the caller's next drive is the only one this step.
  task automatic send_point(input logic first, input logic [COORD_BITS-1:0] x,
                            input logic [COORD_BITS-1:0] y);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{first_point: first, x_coord: x, y_coord: y};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Depth writes only with the core idle: drain all owed results, give the
  // core its worst-case point time to finish the commit, then write.
  task automatic write_depth(input logic [DEPTH_W-1:0] depth);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= depth;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A well-formed stream: first_point on the lead beat, y non-increasing,
  // x non-increasing on y ties. The x shape varies so that drops, band
  // points and skyline points all show up in volume.
  task automatic send_run(input int unsigned n);
    int unsigned           shape;
    int unsigned           step;
    int unsigned           nx;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] base;
    shape = $urandom_range(3);
    base  = 16'($urandom_range(65535));
    x     = base;
    y     = 16'($urandom_range(65535, 8192));
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        step = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 900);
        if (step > y) begin
          step = y;
        end
        y = y - 16'(step);
      end
      case (shape)
        0: nx = $urandom_range(65535);
        1: nx = (base > 65519) ? 65535 - $urandom_range(15) : base + $urandom_range(15);
        2: nx = x + $urandom_range(2500);    // climbing, mostly skyline
        default: begin
          case ($urandom_range(4))
            0: nx = 0;
            1: nx = 1;
            2: nx = 65534;
            3: nx = 65535;
            default: nx = $urandom_range(65535);
          endcase
        end
      endcase
      if (nx > 65535) begin
        nx = 65535;
      end
      // equal y must come with x not above the previous one
      if (i > 0 && step == 0 && nx > x) begin
        nx = $urandom_range(x);
      end
      x = 16'(nx);
      send_point(i == 0, x, y);
    end
  endtask

  initial begin : stimulus
    int unsigned        gap_mix   [4] = '{0, 54, 0, 21};
    int unsigned        stall_mix [4] = '{0, 0, 54, 21};
    logic [DEPTH_W-1:0] depth_edges [5] = '{0, 1, 16, 17, 31};
    logic [DEPTH_W-1:0] depth;
    int unsigned        sent;
    int unsigned        n;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: reset depth (k = 1) ----
    send_point(1'b1, 16'h0000, 16'hFFFF);   // zero x: band, never skyline
    send_point(1'b0, 16'h0000, 16'hFFFF);   // y tie, not above held min: drop
    send_point(1'b0, 16'hFFFF, 16'h8000);   // top x: skyline
    send_point(1'b0, 16'hFFFF, 16'h0000);   // equal to held min: drop
    send_point(1'b1, 16'h1234, 16'h0000);   // first_point clears mid-stream

    // depth zero behaves as one
    write_depth('0);
    send_point(1'b1, 16'h8000, 16'hFFFF);
    send_point(1'b0, 16'h7FFF, 16'h7000);
    send_point(1'b0, 16'h8001, 16'h6000);

    // depth above MAX_BAND clamps; overfill the set
    write_depth('1);
    send_point(1'b1, 16'h0100, 16'hFFFF);
    for (int i = 1; i <= MAX_BAND + 1; i++) begin
      send_point(1'b0, 16'($urandom_range(65535)), 16'hFFFF - 16'(i * 256));
    end

    // depth lowered with a full set: replacement keeps the set at 16
    write_depth(5'd3);
    send_point(1'b0, 16'h0000, 16'h0800);
    send_point(1'b0, 16'hFFFF, 16'h0400);
    send_point(1'b0, 16'($urandom_range(65535)), 16'h0200);

    // ---- random: four idle mixes, three depth settings each ----
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = gap_mix[ph];
      stall_pct = stall_mix[ph];
      for (int s = 0; s < 3; s++) begin
        if (ph == 0 && s == 0) begin
          depth = 5'd16;
        end else if ($urandom_range(3) == 0) begin
          depth = depth_edges[$urandom_range(4)];
        end else begin
          depth = DEPTH_W'($urandom_range(MAX_BAND, 1));
        end
        write_depth(depth);
        sent = 0;
        while (sent < RUN_POINTS) begin
          if ($urandom_range(9) == 0) begin
            // noise: unsorted, random first_point
            send_point($urandom_range(7) == 0, 16'($urandom_range(65535)),
                       16'($urandom_range(65535)));
            sent++;
          end else begin
            n = $urandom_range(40, 1);
            send_run(n);
            sent += n;
          end
        end
      end
    end

    // ---- drain and verdict ----
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("k_skyband_filter_core test passed");
    end else begin
      $display("k_skyband_filter_core test failed");
    end
    $finish;
  end

endmodule
